// ===== src/rc_link_frame_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// RC link frame parser assertion macros
// Shared property wrappers for the checker of the frame parser core.
// ----------------------------------------------------------------------------
`ifndef RC_LINK_FRAME_PARSER_CORE_ASSERT_SVH
`define RC_LINK_FRAME_PARSER_CORE_ASSERT_SVH

// Checked on every rising edge once reset has been released
`define RCLFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included
`define RCLFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/rclfp_pkg.sv =====
// ----------------------------------------------------------------------------
// RC link frame parser package
// Constants, register map, types and the CRC-8 step shared by the parser.
// ----------------------------------------------------------------------------
package rclfp_pkg;

  // Default sizing
  localparam int unsigned NUM_CHANNELS_DEF = 16;
  localparam int unsigned MAX_PAYLOAD_DEF  = 22;
  localparam int unsigned STATS_BYTES_DEF  = 10;

  // Fixed field widths and frame constants
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CH_BITS  = 11;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned STS_W    = 2;
  localparam int unsigned MIN_LEN  = 3;
  localparam logic [7:0]  CRC_POLY = 8'hD5;

  // Unpacking bit buffer: at most CH_BITS-1 bits left plus one new byte
  localparam int unsigned BUF_W = CH_BITS + BYTE_W - 1;
  localparam int unsigned CNT_W = $clog2(BUF_W + 1);

  // APB register map
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;
  localparam logic [1:0]  REG_SYNC     = 2'd0;
  localparam logic [1:0]  REG_CH_TYPE  = 2'd1;
  localparam logic [1:0]  REG_ST_TYPE  = 2'd2;
  localparam logic [1:0]  REG_ST_EN    = 2'd3;

  localparam logic [7:0] SYNC_RST    = 8'd200;
  localparam logic [7:0] CH_TYPE_RST = 8'd22;
  localparam logic [7:0] ST_TYPE_RST = 8'd20;
  localparam logic       ST_EN_RST   = 1'b1;

  // Result status codes
  typedef enum logic [STS_W-1:0] {
    ST_ERROR   = 2'd0,
    ST_CHANNEL = 2'd1,
    ST_STATS   = 2'd2
  } res_status_e;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] channels_type;
    logic [7:0] stats_type;
    logic       stats_en;
  } cfg_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_CH_RD,
    S_CH_LD,
    S_CH_OUT,
    S_ST_RD,
    S_ST_OUT
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic consume;
    logic load_err;
    logic rd_chan;
    logic ld_chan;
    logic out_chan;
    logic rd_stats;
    logic out_stats;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ev_err;
    logic ev_chan;
    logic ev_stats;
    logic ld_enough;
    logic out_more;
    logic chan_last;
    logic stats_last;
    logic slot_free;
  } dp_stat_t;

  // One byte of CRC-8, MSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] din);
    logic [7:0] c;
    c = crc ^ din;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== src/rclfp_regs.sv =====
// ----------------------------------------------------------------------------
// RC link frame parser configuration registers
// APB register file holding sync byte, type codes and statistics enable.
// ----------------------------------------------------------------------------
module rclfp_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rclfp_pkg::APB_AW-1:0] paddr,
  input  logic [rclfp_pkg::APB_DW-1:0] pwdata,
  output logic [rclfp_pkg::APB_DW-1:0] prdata,
  output logic                         pready,
  output rclfp_pkg::cfg_t              cfg_o
);
  import rclfp_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel & penable & pwrite;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SYNC:    cfg_d.sync_value    = pwdata[7:0];
        REG_CH_TYPE: cfg_d.channels_type = pwdata[7:0];
        REG_ST_TYPE: cfg_d.stats_type    = pwdata[7:0];
        REG_ST_EN:   cfg_d.stats_en      = pwdata[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value    <= SYNC_RST;
      cfg_q.channels_type <= CH_TYPE_RST;
      cfg_q.stats_type    <= ST_TYPE_RST;
      cfg_q.stats_en      <= ST_EN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back mux
  always_comb begin
    unique case (reg_idx)
      REG_SYNC:    prdata = APB_DW'(cfg_q.sync_value);
      REG_CH_TYPE: prdata = APB_DW'(cfg_q.channels_type);
      REG_ST_TYPE: prdata = APB_DW'(cfg_q.stats_type);
      REG_ST_EN:   prdata = APB_DW'(cfg_q.stats_en);
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/rclfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// RC link frame parser controller
// Sequences byte intake, error reporting, channel unpacking and stats output.
// ----------------------------------------------------------------------------
module rclfp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  rclfp_pkg::dp_stat_t stat_i,
  output logic                in_ready_o,
  output rclfp_pkg::dp_cmd_t  cmd_o
);
  import rclfp_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.ev_err) begin
            state_d = S_ERR;
          end else if (stat_i.ev_chan) begin
            state_d = S_CH_RD;
          end else if (stat_i.ev_stats) begin
            state_d = S_ST_RD;
          end
        end
      end
      S_ERR: begin
        if (stat_i.slot_free) state_d = S_IDLE;
      end
      S_CH_RD: state_d = S_CH_LD;
      S_CH_LD: state_d = stat_i.ld_enough ? S_CH_OUT : S_CH_RD;
      S_CH_OUT: begin
        if (stat_i.slot_free) begin
          if (stat_i.chan_last) begin
            state_d = S_IDLE;
          end else if (stat_i.out_more) begin
            state_d = S_CH_OUT;
          end else begin
            state_d = S_CH_RD;
          end
        end
      end
      S_ST_RD: state_d = S_ST_OUT;
      S_ST_OUT: begin
        if (stat_i.slot_free) state_d = stat_i.stats_last ? S_IDLE : S_ST_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.consume = in_valid_i;
      end
      S_ERR:    cmd_o.load_err  = stat_i.slot_free;
      S_CH_RD:  cmd_o.rd_chan   = 1'b1;
      S_CH_LD:  cmd_o.ld_chan   = 1'b1;
      S_CH_OUT: cmd_o.out_chan  = stat_i.slot_free;
      S_ST_RD:  cmd_o.rd_stats  = 1'b1;
      S_ST_OUT: cmd_o.out_stats = stat_i.slot_free;
      default:  cmd_o           = '0;
    endcase
  end

endmodule

// ===== src/rclfp_dp.sv =====
// ----------------------------------------------------------------------------
// RC link frame parser datapath
// Frame tracking, CRC, payload memory, channel bit unpacker, result register.
// ----------------------------------------------------------------------------
module rclfp_dp #(
  parameter int unsigned NUM_CHANNELS = rclfp_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned MAX_PAYLOAD  = rclfp_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned STATS_BYTES  = rclfp_pkg::STATS_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rclfp_pkg::cfg_t               cfg_i,
  input  rclfp_pkg::dp_cmd_t            cmd_i,
  input  logic [rclfp_pkg::BYTE_W-1:0]  rx_byte_i,
  input  logic                          out_ready_i,
  output rclfp_pkg::dp_stat_t           stat_o,
  output logic                          out_valid_o,
  output logic [rclfp_pkg::STS_W-1:0]   status_o,
  output logic [rclfp_pkg::IDX_W-1:0]   item_index_o,
  output logic [rclfp_pkg::CH_BITS-1:0] value_o,
  output logic                          last_o
);
  import rclfp_pkg::*;

  localparam int unsigned AW      = $clog2(MAX_PAYLOAD);
  localparam int unsigned PW      = $clog2(MAX_PAYLOAD + 4);
  localparam int unsigned MAX_LEN = MAX_PAYLOAD + 2;

  // Frame tracking state
  logic          in_frame_q, in_frame_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] len_q, len_d;
  logic [7:0]    type_q, type_d;
  logic [7:0]    crc_q, crc_d;

  logic          pos_len, pos_type, pos_pay, is_end, len_bad, crc_ok, run_start;
  logic [7:0]    crc_next;

  // Payload memory
  logic [7:0]             mem_q [MAX_PAYLOAD];
  logic [MAX_PAYLOAD-1:0] vld_q;
  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [7:0]             rd_data_q, rd_byte;
  logic                   rd_vld_q;

  // Unpacker
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BUF_W-1:0] buf_q, buf_d;
  logic [IDX_W-1:0] item_q, item_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic [STS_W-1:0]   status_q, status_d;
  logic [IDX_W-1:0]   index_q, index_d;
  logic [CH_BITS-1:0] value_q, value_d;
  logic               last_q, last_d;
  logic               load_out;

  // Byte classification against the frame position
  assign pos_len  = (pos_q == '0);
  assign pos_type = (pos_q == PW'(2));
  assign pos_pay  = !pos_len && !pos_type && (pos_q <= len_q);
  assign is_end   = in_frame_q && !pos_len && !pos_type && !pos_pay;
  assign len_bad  = (rx_byte_i < 8'(MIN_LEN)) || (rx_byte_i > 8'(MAX_LEN));
  assign crc_ok   = (rx_byte_i == crc_q);
  assign crc_next = crc8_update(crc_q, rx_byte_i);

  assign stat_o.ev_err   = in_frame_q && ((pos_len && len_bad) || (is_end && !crc_ok));
  assign stat_o.ev_chan  = is_end && crc_ok && (type_q == cfg_i.channels_type);
  assign stat_o.ev_stats = is_end && crc_ok && (type_q != cfg_i.channels_type) &&
                           (type_q == cfg_i.stats_type) && cfg_i.stats_en;

  assign run_start = cmd_i.consume && (stat_o.ev_chan || stat_o.ev_stats);

  // Frame state update on each consumed byte
  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    len_d      = len_q;
    type_d     = type_q;
    crc_d      = crc_q;
    if (cmd_i.consume) begin
      if (!in_frame_q) begin
        if (rx_byte_i == cfg_i.sync_value) begin
          in_frame_d = 1'b1;
          pos_d      = '0;
        end
      end else if (pos_len) begin
        if (len_bad) begin
          in_frame_d = 1'b0;
        end else begin
          len_d = PW'(rx_byte_i);
          crc_d = '0;
          pos_d = PW'(2);
        end
      end else if (pos_type) begin
        type_d = rx_byte_i;
        crc_d  = crc_next;
        pos_d  = PW'(3);
      end else if (pos_pay) begin
        crc_d = crc_next;
        pos_d = pos_q + PW'(1);
      end else begin
        in_frame_d = 1'b0;
        pos_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
    end
  end

  // len and type are written before any use; crc is cleared on the length byte
  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    type_q <= type_d;
    crc_q  <= crc_d;
  end

  // Payload memory: one write port, one registered read port
  assign wr_en   = cmd_i.consume && in_frame_q && pos_pay;
  assign wr_addr = AW'(pos_q - PW'(3));
  assign rd_en   = cmd_i.rd_chan || cmd_i.rd_stats;
  assign rd_addr = cmd_i.rd_stats ? AW'(item_q) : rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= rx_byte_i;
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  assign rd_byte = rd_vld_q ? rd_data_q : 8'd0;

  // Channel unpacker: bytes enter LSB-first, 11 bits leave per channel
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    buf_d    = buf_q;
    item_d   = item_q;
    if (run_start) begin
      rd_ptr_d = '0;
      cnt_d    = '0;
      buf_d    = '0;
      item_d   = '0;
    end else begin
      if (cmd_i.rd_chan) rd_ptr_d = rd_ptr_q + AW'(1);
      if (cmd_i.ld_chan) begin
        buf_d = buf_q | (BUF_W'(rd_byte) << cnt_q);
        cnt_d = cnt_q + CNT_W'(BYTE_W);
      end
      if (cmd_i.out_chan) begin
        buf_d  = buf_q >> CH_BITS;
        cnt_d  = cnt_q - CNT_W'(CH_BITS);
        item_d = item_q + IDX_W'(1);
      end
      if (cmd_i.out_stats) item_d = item_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      buf_q    <= '0;
      item_q   <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      buf_q    <= buf_d;
      item_q   <= item_d;
    end
  end

  assign stat_o.ld_enough  = (cnt_q >= CNT_W'(CH_BITS - BYTE_W));
  assign stat_o.out_more   = (cnt_q >= CNT_W'(2 * CH_BITS));
  assign stat_o.chan_last  = (item_q == IDX_W'(NUM_CHANNELS - 1));
  assign stat_o.stats_last = (item_q == IDX_W'(STATS_BYTES - 1));
  assign stat_o.slot_free  = !out_valid_q || out_ready_i;

  // Result register
  assign load_out = cmd_i.load_err || cmd_i.out_chan || cmd_i.out_stats;

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    index_d     = index_q;
    value_d     = value_q;
    last_d      = last_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      if (cmd_i.out_chan) begin
        status_d = ST_CHANNEL;
        index_d  = item_q;
        value_d  = buf_q[CH_BITS-1:0];
        last_d   = stat_o.chan_last;
      end else if (cmd_i.out_stats) begin
        status_d = ST_STATS;
        index_d  = item_q;
        value_d  = CH_BITS'(rd_byte);
        last_d   = stat_o.stats_last;
      end else begin
        status_d = ST_ERROR;
        index_d  = '0;
        value_d  = '0;
        last_d   = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    index_q  <= index_d;
    value_q  <= value_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign item_index_o = index_q;
  assign value_o      = value_q;
  assign last_o       = last_q;

endmodule

// ===== src/rc_link_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// RC link frame parser core
// Byte-serial RC link frame parser with CRC-8 (0xD5) check and result stream.
// ----------------------------------------------------------------------------
//  port group | direction | signals
//  -----------+-----------+------------------------------------------------
//  rx byte    | in        | in_valid_i / in_ready_o, rx_byte_i
//  result     | out       | out_valid_o / out_ready_i, status_o, item_index_o,
//             |           | value_o, last_o
//  config     | in        | APB: psel, penable, pwrite, paddr, pwdata, prdata
//
//  After a byte that yields no result the next byte can follow at once.
//  An error result waits for a free result slot before the next byte is taken.
//  A channel frame end does one payload memory read and one unpack step per byte
//  and one output step per channel; a stats frame end does one read and one
//  output per stats byte. A stalled result holds the sequence in place.
//  Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rc_link_frame_parser_core #(
  parameter int unsigned NUM_CHANNELS = rclfp_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned MAX_PAYLOAD  = rclfp_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned STATS_BYTES  = rclfp_pkg::STATS_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rclfp_pkg::BYTE_W-1:0]  rx_byte_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rclfp_pkg::STS_W-1:0]   status_o,
  output logic [rclfp_pkg::IDX_W-1:0]   item_index_o,
  output logic [rclfp_pkg::CH_BITS-1:0] value_o,
  output logic                          last_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rclfp_pkg::APB_AW-1:0]  paddr,
  input  logic [rclfp_pkg::APB_DW-1:0]  pwdata,
  output logic [rclfp_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import rclfp_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  rclfp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rclfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  rclfp_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .STATS_BYTES  (STATS_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .rx_byte_i    (rx_byte_i),
    .out_ready_i  (out_ready_i),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .item_index_o (item_index_o),
    .value_o      (value_o),
    .last_o       (last_o)
  );

endmodule

// ===== src/rclfp_checker.sv =====
// ----------------------------------------------------------------------------
// RC link frame parser checker
// Port-level properties of the parser core, bound to the top level.
// ----------------------------------------------------------------------------
`include "rc_link_frame_parser_core_assert.svh"

module rclfp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [rclfp_pkg::STS_W-1:0]   status_o,
  input logic [rclfp_pkg::IDX_W-1:0]   item_index_o,
  input logic [rclfp_pkg::CH_BITS-1:0] value_o,
  input logic                          last_o
);
  import rclfp_pkg::*;

  // Status is never the unused code
  `RCLFP_ASSERT_ALWAYS(a_status_code, !out_valid_o || status_o != 2'd3, "bad status code")

  // An error result is a single, empty, final transfer
  `RCLFP_ASSERT(a_err_form, out_valid_o && status_o == ST_ERROR |-> last_o && item_index_o == '0 && value_o == '0, "malformed error result")

  // A statistics result carries one byte
  `RCLFP_ASSERT(a_stats_byte, out_valid_o && status_o == ST_STATS |-> value_o[CH_BITS-1:BYTE_W] == '0, "stats value wider than a byte")

  // No byte is taken while a run is still being delivered
  `RCLFP_ASSERT(a_run_blocks_in, out_valid_o && !last_o |-> !in_ready_o, "input taken mid-run")

  // A stalled result stays on offer
  `RCLFP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result withdrawn")

endmodule

bind rc_link_frame_parser_core rclfp_checker u_rclfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .item_index_o (item_index_o),
  .value_o      (value_o),
  .last_o       (last_o)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC link frame parser testbench
// Feeds the parser byte streams of good, short, corrupt and noisy frames
// under several register settings and idle patterns. Every result is
// predicted per accepted byte and checked in order against the result port.
// ----------------------------------------------------------------------------
module testbench;
  import rclfp_pkg::*;

  localparam int unsigned PAYLOAD_MAX  = MAX_PAYLOAD_DEF;
  localparam int unsigned CHANNELS     = NUM_CHANNELS_DEF;
  localparam int unsigned STATS_COUNT  = STATS_BYTES_DEF;
  localparam logic [7:0]  LEN_MAX      = 8'(PAYLOAD_MAX + 2);
  // extra wait after the results run dry, covering the longest frame end with margin
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASE_BYTES  = 100;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_SYNC} fill_e;

  typedef struct {
    res_status_e        status;
    logic [IDX_W-1:0]   position;
    logic [CH_BITS-1:0] value;
    logic               last;
  } frame_result_t;

  // DUT ports
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [BYTE_W-1:0]   rx_byte_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STS_W-1:0]    status_o;
  logic [IDX_W-1:0]    item_index_o;
  logic [CH_BITS-1:0]  value_o;
  logic                last_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [APB_AW-1:0]   paddr       = '0;
  logic [APB_DW-1:0]   pwdata      = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Predictor copy of the registers and the parser state
  logic [7:0] cfg_sync       = SYNC_RST;
  logic [7:0] cfg_chan_type  = CH_TYPE_RST;
  logic [7:0] cfg_stats_type = ST_TYPE_RST;
  logic       cfg_stats_en   = ST_EN_RST;
  logic       locked         = 1'b0;
  int unsigned frame_pos     = 0;
  logic [7:0] frame_len      = '0;
  logic [7:0] frame_kind     = '0;
  logic [7:0] crc_acc        = '0;
  logic [7:0] payload_mem [PAYLOAD_MAX] = '{default: 8'h00};

  frame_result_t pending_results[$];

  int fail_count    = 0;
  int live_bytes    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;
  int hold_left     = 0;

  rc_link_frame_parser_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .item_index_o (item_index_o),
    .value_o      (value_o),
    .last_o       (last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endfunction

  // CRC-8, poly 0xD5, MSB first, one input bit per step
  function automatic logic [7:0] crc_d5_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ data[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  function automatic void push_result(input res_status_e st, input int unsigned pos,
                                      input logic [CH_BITS-1:0] val, input logic last);
    frame_result_t r;
    r.status   = st;
    r.position = pos[IDX_W-1:0];
    r.value    = val;
    r.last     = last;
    pending_results.push_back(r);
  endfunction

  // Advance the parser by one byte and queue whatever results it yields
  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [8*PAYLOAD_MAX+CH_BITS-1:0] bits;
    if (!locked) begin
      if (b == cfg_sync) begin
        locked    = 1'b1;
        frame_pos = 0;
      end
    end else if (frame_pos == 0) begin
      frame_len = b;
      if (b < MIN_LEN || b > LEN_MAX) begin
        locked = 1'b0;
        push_result(ST_ERROR, 0, '0, 1'b1);
      end else begin
        crc_acc   = '0;
        frame_pos = 2;
      end
    end else if (frame_pos == 2) begin
      frame_kind = b;
      crc_acc    = crc_d5_step(crc_acc, b);
      frame_pos  = 3;
    end else if (frame_pos <= frame_len) begin
      if (frame_pos - 3 < PAYLOAD_MAX) begin
        payload_mem[frame_pos - 3] = b;
      end
      crc_acc = crc_d5_step(crc_acc, b);
      frame_pos++;
    end else begin
      // check byte: the frame ends here whatever happens
      locked = 1'b0;
      if (b != crc_acc) begin
        push_result(ST_ERROR, 0, '0, 1'b1);
      end else if (frame_kind == cfg_chan_type) begin
        bits = '0;
        for (int k = 0; k < PAYLOAD_MAX; k++) bits[8*k +: 8] = payload_mem[k];
        for (int i = 0; i < CHANNELS; i++) begin
          push_result(ST_CHANNEL, i, bits[CH_BITS*i +: CH_BITS], i == CHANNELS - 1);
        end
      end else if (frame_kind == cfg_stats_type && cfg_stats_en) begin
        for (int i = 0; i < STATS_COUNT; i++) begin
          push_result(ST_STATS, i, CH_BITS'(payload_mem[i]), i == STATS_COUNT - 1);
        end
      end
    end
  endfunction

  // Result side: ready pattern, with a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker: each transfer against the oldest expectation
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result st=%0d idx=%0d val=%0h last=%0b",
                               status_o, item_index_o, value_o, last_o));
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || item_index_o !== want.position ||
            value_o !== want.value || last_o !== want.last) begin
          note_failure($sformatf({"mismatch: exp st=%0d idx=%0d val=%0h last=%0b,",
                                  " got st=%0d idx=%0d val=%0h last=%0b"},
                                 want.status, want.position, want.value, want.last,
                                 status_o, item_index_o, value_o, last_o));
        end
      end
    end
  end

  // One byte transfer, with an optional idle gap in front
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (locked || b == cfg_sync) live_bytes++;
    parse_rx_byte(b);
  endtask

  // Complete frame: sync, length, type, len-2 payload bytes, check byte
  task automatic send_frame(input logic [7:0] len, input logic [7:0] kind,
                            input fill_e fill, input bit bad_crc);
    logic [7:0] body[$];
    logic [7:0] crc;
    for (int k = 0; k < len - 2; k++) begin
      case (fill)
        FILL_ONES:  body.push_back(8'hFF);
        FILL_ZEROS: body.push_back(8'h00);
        FILL_SYNC:  body.push_back(k[0] ? 8'($urandom_range(255)) : cfg_sync);
        default:    body.push_back(8'($urandom_range(255)));
      endcase
    end
    crc = crc_d5_step(8'h00, kind);
    foreach (body[k]) crc = crc_d5_step(crc, body[k]);
    send_byte(cfg_sync);
    send_byte(len);
    send_byte(kind);
    foreach (body[k]) send_byte(body[k]);
    send_byte(bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc);
  endtask

  task automatic send_bad_length(input logic [7:0] len);
    send_byte(cfg_sync);
    send_byte(len);
  endtask

  // Finish any open frame, then let the result stream run dry
  task automatic quiesce();
    while (locked) send_byte(8'($urandom_range(255)));
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write followed by a read back of the same register
  task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] data);
    logic [APB_DW-1:0] mask;
    mask    = (idx == REG_ST_EN) ? 32'h1 : 32'hFF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_SYNC:    cfg_sync       = data[7:0];
      REG_CH_TYPE: cfg_chan_type  = data[7:0];
      REG_ST_TYPE: cfg_stats_type = data[7:0];
      REG_ST_EN:   cfg_stats_en   = data[0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== (data & mask)) begin
      note_failure($sformatf("register %0d reads %0h, expected %0h",
                             idx, prdata & mask, data & mask));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic randomise_registers();
    write_reg(REG_SYNC, pick_code());
    write_reg(REG_CH_TYPE, pick_code());
    write_reg(REG_ST_TYPE, pick_code());
    write_reg(REG_ST_EN, $urandom_range(1));
  endtask

  // Mostly well-formed frames; some noise, bad lengths and cut-short frames
  task automatic send_random_frame();
    int unsigned pick;
    logic [7:0]  len;
    logic [7:0]  kind;
    pick = $urandom_range(99);
    len  = ($urandom_range(2) == 0) ? LEN_MAX : 8'($urandom_range(MIN_LEN, LEN_MAX));
    case ($urandom_range(9))
      0, 1, 2, 3: kind = cfg_chan_type;
      4, 5, 6:    kind = cfg_stats_type;
      default:    kind = 8'($urandom_range(255));
    endcase
    if (pick < 6) begin
      // line noise
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
    end else if (pick < 12) begin
      send_bad_length($urandom_range(1) ? 8'($urandom_range(MIN_LEN - 1))
                                        : 8'($urandom_range(LEN_MAX + 1, 255)));
    end else if (pick < 18) begin
      // cut short: the following frame's bytes land inside this one
      send_byte(cfg_sync);
      send_byte(len);
      send_byte(kind);
      repeat ($urandom_range(len - 3)) send_byte(8'($urandom_range(255)));
    end else begin
      send_frame(len, kind, FILL_RANDOM, $urandom_range(9) == 0);
    end
  endtask

  // ---- test tasks ----

  task automatic test_channel_unpacking();
    send_frame(LEN_MAX, cfg_chan_type, FILL_ONES, 1'b0);
    send_frame(LEN_MAX, cfg_chan_type, FILL_ZEROS, 1'b0);
    send_frame(LEN_MAX, cfg_chan_type, FILL_RANDOM, 1'b0);
    // short frame: the tail of the store keeps the previous payload
    send_frame(6, cfg_chan_type, FILL_RANDOM, 1'b0);
    // sync value inside a frame is plain data
    send_frame(LEN_MAX, cfg_chan_type, FILL_SYNC, 1'b0);
    quiesce();
  endtask

  task automatic test_length_limits();
    send_bad_length(8'd0);
    send_bad_length(8'(MIN_LEN - 1));
    send_bad_length(8'(LEN_MAX + 1));
    send_bad_length(8'hFF);
    send_bad_length(cfg_sync);
    // shortest and longest legal frames of an unknown type give nothing
    send_frame(8'(MIN_LEN), 8'h00, FILL_RANDOM, 1'b0);
    send_frame(LEN_MAX, 8'h00, FILL_RANDOM, 1'b0);
    quiesce();
  endtask

  task automatic test_crc_errors();
    send_frame(LEN_MAX, cfg_chan_type, FILL_RANDOM, 1'b1);
    send_frame(12, cfg_stats_type, FILL_RANDOM, 1'b1);
    send_frame(8'(MIN_LEN), 8'h00, FILL_RANDOM, 1'b1);
    quiesce();
  endtask

  task automatic test_stats_frames();
    send_frame(LEN_MAX, cfg_stats_type, FILL_RANDOM, 1'b0);
    // short stats frame reads older bytes from the store
    send_frame(5, cfg_stats_type, FILL_ONES, 1'b0);
    quiesce();
  endtask

  task automatic test_register_settings();
    // low sync, equal type codes at the top: channel decode wins
    write_reg(REG_SYNC, 32'h00);
    write_reg(REG_CH_TYPE, 32'hFF);
    write_reg(REG_ST_TYPE, 32'hFF);
    send_frame(LEN_MAX, 8'hFF, FILL_RANDOM, 1'b0);
    send_frame(12, 8'hFF, FILL_SYNC, 1'b0);
    quiesce();
    // statistics off: upper data bits are ignored by the one-bit register
    write_reg(REG_ST_TYPE, 32'h00);
    write_reg(REG_ST_EN, 32'hFFFF_FFFE);
    send_frame(LEN_MAX, 8'h00, FILL_RANDOM, 1'b0);
    send_frame(LEN_MAX, 8'hFF, FILL_ONES, 1'b0);
    quiesce();
    write_reg(REG_SYNC, 32'hFF);
    write_reg(REG_ST_EN, 32'h1);
    send_frame(8, 8'h00, FILL_SYNC, 1'b0);
    quiesce();
    write_reg(REG_SYNC, SYNC_RST);
    write_reg(REG_CH_TYPE, CH_TYPE_RST);
    write_reg(REG_ST_TYPE, ST_TYPE_RST);
    write_reg(REG_ST_EN, ST_EN_RST);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall);
    int goal;
    randomise_registers();
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    goal          = live_bytes + PHASE_BYTES;
    while (live_bytes < goal) begin
      send_random_frame();
      // now and then the sender waits for the results to run dry
      if ($urandom_range(19) == 0) quiesce();
    end
    quiesce();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = HOLD_CYCLES;
    repeat (3) send_frame(LEN_MAX, cfg_chan_type, FILL_RANDOM, 1'b0);
    send_frame(LEN_MAX, cfg_stats_type, FILL_RANDOM, 1'b0);
    quiesce();
  endtask

  // Test sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_channel_unpacking();
    test_length_limits();
    test_crc_errors();
    test_stats_frames();
    test_register_settings();
    test_random_traffic(0, 0);
    test_random_traffic(66, 0);
    test_random_traffic(0, 66);
    test_random_traffic(10, 10);
    test_output_backpressure();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
